/* sv/frud_pkg.sv */
package frud_pkg;

    localparam int unsigned DEF_PANEL_WIDTH  = 792;
    localparam int unsigned DEF_PANEL_HEIGHT = 272;

    localparam logic [31:0] SYNC_WORD = 32'h4D574631;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [15:0] HDR_TIMEOUT_RST = 16'd2000;
    localparam logic [15:0] PAY_TIMEOUT_RST = 16'd8000;

    localparam int unsigned BIT_FULL = 0;
    localparam int unsigned BIT_RECT = 1;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_CLEAR_FULL   = 2'd0,
        MODE_PARTIAL_FULL = 2'd1,
        MODE_WINDOW       = 2'd2
    } mode_t;

    localparam logic REG_HDR_TIMEOUT = 1'b0;
    localparam logic REG_PAY_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  rx_byte;
        logic [14:0] read_address;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  update_mode;
        logic [9:0]  rect_x;
        logic [8:0]  rect_y;
        logic [9:0]  rect_w;
        logic [8:0]  rect_h;
        logic [7:0]  read_data;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic take;       // register incoming item
        logic do_byte;    // run byte step
        logic do_tick;    // run tick step
        logic do_read;    // start a store read
        logic chk;        // frame validity check
        logic copy_start;
        logic copy_step;
        logic load_out;   // latch result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic byte_op;
        logic tick_op;
        logic read_op;
        logic frame_done;  // CRC matched on last byte
        logic frame_ok;    // check passed
        logic copy_last;
        logic clearing;    // store clear pass after reset
    } sts_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

endpackage

/* sv/frud_if.sv */
interface frud_in_if import frud_pkg::*; ;
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface frud_out_if import frud_pkg::*; ;
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* sv/frud_ctrl.sv */
module frud_ctrl import frud_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_RDWT = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_CPY0 = 7'b0010000,
        S_COPY = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == S_IDLE) && !ov_reg && !sts.clearing;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.read_op)
                begin
                    cmd.do_read = 1'b1;
                    state_next  = S_RDWT;
                end
                else if (sts.byte_op)
                begin
                    cmd.do_byte = 1'b1;
                    state_next  = sts.frame_done ? S_CHK : S_IDLE;
                end
                else
                begin
                    cmd.do_tick = sts.tick_op;
                    state_next  = S_IDLE;
                end
            end
            S_RDWT:
            begin
                state_next = S_OUT;
            end
            S_CHK:
            begin
                cmd.chk    = 1'b1;
                state_next = S_CPY0;
            end
            S_CPY0:
            begin
                if (sts.frame_ok)
                begin
                    cmd.copy_start = 1'b1;
                    state_next     = S_COPY;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (sts.copy_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.load_out = 1'b1;
                ov_next      = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

/* sv/frud_dp.sv */
module frud_dp import frud_pkg::*; #(
    parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [15:0] cfg_data,
    input  in_item_t  in_item,
    input  cmd_t      cmd,
    output sts_t      sts,
    output out_item_t out_item
);

    localparam int unsigned ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
    localparam int unsigned STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam int unsigned PAYLOAD_MAX = STORE_BYTES + 9;
    localparam int unsigned AW  = $clog2(PAYLOAD_MAX + 1);
    localparam int unsigned FAW = $clog2(STORE_BYTES + 1);
    localparam int unsigned CW  = $clog2(ROW_BYTES + 1);
    localparam int unsigned RW  = $clog2(PANEL_HEIGHT + 1);
    localparam int unsigned PW  = $clog2(PANEL_WIDTH + 1);
    localparam int unsigned NW  = AW + CW + RW;
    localparam logic [1:0] PH_HUNT = 2'd0, PH_LEN = 2'd1, PH_PAY = 2'd2, PH_CRC = 2'd3;

    logic [15:0] hdr_to_reg, pay_to_reg;
    in_item_t    item_reg;
    logic [31:0] sync_reg, crc_reg, exp_reg;
    logic [1:0]  ph_reg;
    logic [AW-1:0] cnt_reg, len_reg;
    logic [15:0] tmr_reg;

    // clear pass after reset writes the whole store white
    logic           clr_busy_reg;
    logic [FAW-1:0] clr_addr_reg;

    logic [7:0] pay_mem [PAYLOAD_MAX];
    logic [7:0] frm_mem [STORE_BYTES];

    // header fields captured while the payload streams in
    logic [7:0]  flags_reg;
    logic [15:0] hx_reg, hy_reg, hw_reg, hh_reg;

    // check results
    logic          ok_reg, full_reg, win_reg;
    logic [PW-1:0] cx_reg, cw_reg;
    logic [RW-1:0] cy_reg, ch_reg;

    // copy walker
    logic [AW-1:0]  src_reg;
    logic [FAW-1:0] dst_reg, rowbase_reg;
    logic [CW-1:0]  col_reg;
    logic [RW-1:0]  row_reg;
    logic           wr_pend_reg;
    logic [FAW-1:0] wr_addr_reg;
    logic [7:0]     pay_rd_reg, frm_rd_reg;
    logic           rd_inrange_reg;

    logic [31:0] shift_in;
    logic [31:0] crc_nx;
    logic [AW-1:0] cnt_inc;
    assign shift_in = {item_reg.rx_byte, exp_reg[31:8]};
    assign crc_nx   = crc_byte(crc_reg, item_reg.rx_byte);
    assign cnt_inc  = cnt_reg + AW'(1);

    // clipped length check from the registered clip results
    logic [NW-1:0] need;
    assign need = NW'(9) + NW'(cw_reg[PW-1:3]) * NW'(ch_reg);

    assign sts.byte_op = item_reg.operation == OP_BYTE;
    assign sts.tick_op = item_reg.operation == OP_TICK;
    assign sts.read_op = item_reg.operation == OP_READ;
    assign sts.frame_done = (ph_reg == PH_CRC) && (cnt_reg == AW'(3))
                            && (shift_in == ~crc_reg);
    assign sts.frame_ok   = ok_reg && (!win_reg || (need == NW'(len_reg)));
    assign sts.copy_last  = (col_reg == cw_reg[PW-1:3] - CW'(1)) &&
                            (row_reg == ch_reg - RW'(1));
    assign sts.clearing   = clr_busy_reg;

    // check combinational terms (registered into ok_reg)
    logic [16:0] xw, yh;
    logic [PW-1:0] w_cl;
    logic [RW-1:0] h_cl;
    assign xw = {1'b0, hx_reg} + {1'b0, hw_reg};
    assign yh = {1'b0, hy_reg} + {1'b0, hh_reg};
    assign w_cl = (xw > 17'(PANEL_WIDTH)) ? PW'(PANEL_WIDTH - hx_reg[PW-1:0])
                                          : hw_reg[PW-1:0];
    assign h_cl = (yh > 17'(PANEL_HEIGHT)) ? RW'(PANEL_HEIGHT - hy_reg[RW-1:0])
                                           : hh_reg[RW-1:0];

    logic rect_ok;
    always_comb
    begin
        rect_ok = (len_reg >= AW'(9)) && (hx_reg[2:0] == 3'd0) && (hw_reg[2:0] == 3'd0)
                  && (hw_reg != 16'd0) && (hh_reg != 16'd0)
                  && (hx_reg < 16'(PANEL_WIDTH)) && (hy_reg < 16'(PANEL_HEIGHT));
    end

    out_item_t out_next;
    always_comb
    begin
        out_next = '0;
        if (item_reg.operation == OP_READ)
        begin
            out_next.result_kind = 1'b1;
            out_next.read_data   = rd_inrange_reg ? frm_rd_reg : 8'd0;
        end
        else if (win_reg && !full_reg)
        begin
            out_next.update_mode = MODE_WINDOW;
            out_next.rect_x      = 10'(cx_reg);
            out_next.rect_y      = 9'(cy_reg);
            out_next.rect_w      = 10'(cw_reg);
            out_next.rect_h      = 9'(ch_reg);
        end
        else
        begin
            out_next.update_mode = full_reg ? MODE_CLEAR_FULL : MODE_PARTIAL_FULL;
            out_next.rect_w      = 10'(PANEL_WIDTH);
            out_next.rect_h      = 9'(PANEL_HEIGHT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_to_reg   <= HDR_TIMEOUT_RST;
            pay_to_reg   <= PAY_TIMEOUT_RST;
            sync_reg     <= '0;
            crc_reg      <= '1;
            exp_reg      <= '0;
            ph_reg       <= PH_HUNT;
            cnt_reg      <= '0;
            len_reg      <= '0;
            tmr_reg      <= '0;
            ok_reg       <= 1'b0;
            wr_pend_reg  <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == FAW'(STORE_BYTES - 1))
                    clr_busy_reg <= 1'b0;
                else
                    clr_addr_reg <= clr_addr_reg + FAW'(1);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_HDR_TIMEOUT)
                    hdr_to_reg <= cfg_data;
                else
                    pay_to_reg <= cfg_data;
            end
            if (cmd.do_byte)
            begin
                case (ph_reg)
                    PH_LEN:
                    begin
                        exp_reg <= shift_in;
                        if (cnt_reg == AW'(3))
                        begin
                            cnt_reg <= '0;
                            tmr_reg <= '0;
                            if (shift_in == 32'd0 || shift_in > 32'(PAYLOAD_MAX))
                                ph_reg <= PH_HUNT;
                            else
                            begin
                                len_reg <= shift_in[AW-1:0];
                                crc_reg <= '1;
                                ph_reg  <= PH_PAY;
                            end
                        end
                        else
                            cnt_reg <= cnt_inc;
                    end
                    PH_PAY:
                    begin
                        crc_reg <= crc_nx;
                        if (cnt_inc >= len_reg)
                        begin
                            exp_reg <= '0;
                            cnt_reg <= '0;
                            tmr_reg <= '0;
                            ph_reg  <= PH_CRC;
                        end
                        else
                            cnt_reg <= cnt_inc;
                    end
                    PH_CRC:
                    begin
                        exp_reg <= shift_in;
                        if (cnt_reg == AW'(3))
                        begin
                            cnt_reg <= '0;
                            tmr_reg <= '0;
                            ph_reg  <= PH_HUNT;
                        end
                        else
                            cnt_reg <= cnt_inc;
                    end
                    default:
                    begin
                        sync_reg <= {sync_reg[23:0], item_reg.rx_byte};
                        if ({sync_reg[23:0], item_reg.rx_byte} == SYNC_WORD)
                        begin
                            exp_reg <= '0;
                            cnt_reg <= '0;
                            tmr_reg <= '0;
                            ph_reg  <= PH_LEN;
                        end
                    end
                endcase
            end
            if (cmd.do_tick && ph_reg != PH_HUNT)
            begin
                if (((tmr_reg == 16'hFFFF) ? tmr_reg : tmr_reg + 16'd1) >=
                    ((ph_reg == PH_PAY) ? pay_to_reg : hdr_to_reg))
                begin
                    ph_reg  <= PH_HUNT;
                    cnt_reg <= '0;
                    tmr_reg <= '0;
                end
                else if (tmr_reg != 16'hFFFF)
                    tmr_reg <= tmr_reg + 16'd1;
            end
            if (cmd.chk)
                ok_reg <= flags_reg[BIT_RECT] ? rect_ok : (len_reg == AW'(STORE_BYTES + 1));
            wr_pend_reg <= cmd.copy_step;
        end
    end

    // payload-side datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.take)
            item_reg <= in_item;
        if (cmd.do_byte && ph_reg == PH_PAY)
        begin
            pay_mem[cnt_reg] <= item_reg.rx_byte;
            case (cnt_reg)
                AW'(0): flags_reg   <= item_reg.rx_byte;
                AW'(1): hx_reg[7:0]  <= item_reg.rx_byte;
                AW'(2): hx_reg[15:8] <= item_reg.rx_byte;
                AW'(3): hy_reg[7:0]  <= item_reg.rx_byte;
                AW'(4): hy_reg[15:8] <= item_reg.rx_byte;
                AW'(5): hw_reg[7:0]  <= item_reg.rx_byte;
                AW'(6): hw_reg[15:8] <= item_reg.rx_byte;
                AW'(7): hh_reg[7:0]  <= item_reg.rx_byte;
                AW'(8): hh_reg[15:8] <= item_reg.rx_byte;
                default: ;
            endcase
        end
        if (cmd.chk)
        begin
            full_reg <= flags_reg[BIT_FULL];
            win_reg  <= flags_reg[BIT_RECT];
            if (flags_reg[BIT_RECT])
            begin
                cx_reg <= hx_reg[PW-1:0];
                cy_reg <= hy_reg[RW-1:0];
                cw_reg <= w_cl;
                ch_reg <= h_cl;
            end
            else
            begin
                cx_reg <= '0;
                cy_reg <= '0;
                cw_reg <= PW'(ROW_BYTES * 8);
                ch_reg <= RW'(PANEL_HEIGHT);
            end
        end
        // copy walk: one payload read per cycle, written to the store in the cycle after
        if (cmd.copy_start)
        begin
            src_reg     <= win_reg ? AW'(9) : AW'(1);
            col_reg     <= '0;
            row_reg     <= '0;
            rowbase_reg <= FAW'(cy_reg * ROW_BYTES + (cx_reg >> 3));
            dst_reg     <= FAW'(cy_reg * ROW_BYTES + (cx_reg >> 3));
        end
        if (cmd.copy_step)
        begin
            pay_rd_reg  <= pay_mem[src_reg];
            wr_addr_reg <= dst_reg;
            src_reg     <= src_reg + AW'(1);
            if (col_reg == cw_reg[PW-1:3] - CW'(1))
            begin
                col_reg     <= '0;
                row_reg     <= row_reg + RW'(1);
                rowbase_reg <= rowbase_reg + FAW'(ROW_BYTES);
                dst_reg     <= rowbase_reg + FAW'(ROW_BYTES);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
                dst_reg <= dst_reg + FAW'(1);
            end
        end
        if (clr_busy_reg)
            frm_mem[clr_addr_reg] <= 8'hFF;
        else if (wr_pend_reg)
            frm_mem[wr_addr_reg] <= pay_rd_reg;
        if (cmd.do_read)
        begin
            frm_rd_reg     <= frm_mem[item_reg.read_address[FAW-1:0]];
            rd_inrange_reg <= 32'(item_reg.read_address) < STORE_BYTES;
        end
        if (cmd.load_out)
            out_item <= out_next;
    end

endmodule

/* sv/framed_rect_update_receiver.sv */
// Byte and tick transfers give no result; a store read passes through execute,
// read wait and output load before its result is offered.
// Accepted frame: after the last CRC byte come the check states (CHK, CPY0), then one
// copied byte per cycle (up to 26928) and the output load before the update command is offered.
// The block takes no new item until the last one is done and its result is taken.
// Reset: rst_n async low; a pass then writes the store white, input held.
module framed_rect_update_receiver import frud_pkg::*; #(
    parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    frud_in_if.sink     in_ch,
    frud_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // controller sequences each transfer; datapath holds the frame and store state
    frud_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_valid(out_ch.valid),
        .out_ready(out_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    frud_dp #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PANEL_HEIGHT(PANEL_HEIGHT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_item  (in_ch.payload),
        .cmd      (cmd),
        .sts      (sts),
        .out_item (out_ch.payload)
    );

endmodule

/* sv/frud_checker.sv */
module frud_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_kind
);

    // one item at a time: no input taken while a result waits
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken with result pending");

    // accept is followed by a busy cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready right after transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_kind))
        else $error("result dropped");

endmodule

bind framed_rect_update_receiver frud_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_kind (out_ch.payload.result_kind)
);

/* tb/sv/frud_checker.sv */
module frud_tb_checker import frud_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    frud_in_if          in_ch,
    frud_out_if         out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int unsigned PANEL_W   = DEF_PANEL_WIDTH;
    localparam int unsigned PANEL_H   = DEF_PANEL_HEIGHT;
    localparam int unsigned ROW_BYTES = (PANEL_W + 7) / 8;
    localparam int unsigned STORE_SZ  = ROW_BYTES * PANEL_H;
    localparam int unsigned BODY_MAX  = STORE_SZ + 9;

    typedef enum logic [1:0] {RX_HUNT, RX_LEN, RX_BODY, RX_CRC} rx_phase_t;

    logic [31:0] sync_sr;
    logic [31:0] field_sr;
    logic [31:0] crc_acc;
    rx_phase_t   phase;
    int unsigned cnt;
    int unsigned body_len;
    logic [15:0] tmr;
    logic [15:0] hdr_lim;
    logic [15:0] pay_lim;
    logic [7:0]  body_mem [BODY_MAX];
    logic [7:0]  pix_mem [STORE_SZ];
    out_item_t   result_q [$];
    out_item_t   exp_res;

    task automatic enter(input rx_phase_t p);
        phase = p;
        cnt   = 0;
        tmr   = '0;
    endtask

    function automatic int unsigned body16(input int unsigned i);
        return 32'({body_mem[i + 1], body_mem[i]});
    endfunction

    // frame validated by CRC: check shape, update store, queue update command
    task automatic commit_frame();
        out_item_t   r;
        int unsigned x, y, w, h, wb, len, d, s;
        logic [7:0]  fl;
        r   = '0;
        len = body_len;
        fl  = body_mem[0];
        if (!fl[BIT_RECT]) begin
            if (len != 1 + STORE_SZ)
                return;
            for (int i = 0; i < STORE_SZ; i++)
                pix_mem[i] = body_mem[i + 1];
            r.update_mode = fl[BIT_FULL] ? MODE_CLEAR_FULL : MODE_PARTIAL_FULL;
            r.rect_w = 10'(PANEL_W);
            r.rect_h = 9'(PANEL_H);
            result_q.push_back(r);
            return;
        end
        if (len < 9)
            return;
        x = body16(1);
        y = body16(3);
        w = body16(5);
        h = body16(7);
        if (x % 8 != 0 || w % 8 != 0 || w == 0 || h == 0)
            return;
        if (x >= PANEL_W || y >= PANEL_H)
            return;
        if (x + w > PANEL_W)
            w = PANEL_W - x;
        if (y + h > PANEL_H)
            h = PANEL_H - y;
        wb = w / 8;
        if (len != 9 + wb * h)
            return;
        for (int unsigned row = 0; row < h; row++) begin
            for (int unsigned col = 0; col < wb; col++) begin
                d = (y + row) * ROW_BYTES + x / 8 + col;
                s = 9 + row * wb + col;
                if (d < STORE_SZ && s < BODY_MAX)
                    pix_mem[d] = body_mem[s];
            end
        end
        if (fl[BIT_FULL]) begin
            r.update_mode = MODE_CLEAR_FULL;
            r.rect_w = 10'(PANEL_W);
            r.rect_h = 9'(PANEL_H);
        end
        else begin
            r.update_mode = MODE_WINDOW;
            r.rect_x = 10'(x);
            r.rect_y = 9'(y);
            r.rect_w = 10'(w);
            r.rect_h = 9'(h);
        end
        result_q.push_back(r);
    endtask

    task automatic take_item(input in_item_t it);
        out_item_t   r;
        logic [7:0]  b;
        logic [15:0] lim;
        r = '0;
        b = it.rx_byte;
        case (op_t'(it.operation))
            OP_BYTE: begin
                case (phase)
                    RX_LEN: begin
                        field_sr = {b, field_sr[31:8]};
                        cnt++;
                        if (cnt >= 4) begin
                            if (field_sr == 0 || field_sr > 32'(BODY_MAX))
                                enter(RX_HUNT);
                            else begin
                                body_len = field_sr;
                                crc_acc  = '1;
                                enter(RX_BODY);
                            end
                        end
                    end
                    RX_BODY: begin
                        if (cnt < BODY_MAX)
                            body_mem[cnt] = b;
                        crc_acc ^= {24'd0, b};
                        repeat (8)
                            crc_acc = crc_acc[0] ? ((crc_acc >> 1) ^ CRC_POLY) : (crc_acc >> 1);
                        cnt++;
                        if (cnt >= body_len) begin
                            field_sr = '0;
                            enter(RX_CRC);
                        end
                    end
                    RX_CRC: begin
                        field_sr = {b, field_sr[31:8]};
                        cnt++;
                        if (cnt >= 4) begin
                            if (field_sr == ~crc_acc)
                                commit_frame();
                            enter(RX_HUNT);
                        end
                    end
                    default: begin
                        sync_sr = {sync_sr[23:0], b};
                        if (sync_sr == SYNC_WORD) begin
                            field_sr = '0;
                            enter(RX_LEN);
                        end
                    end
                endcase
            end
            OP_TICK: begin
                if (phase != RX_HUNT) begin
                    lim = (phase == RX_BODY) ? pay_lim : hdr_lim;
                    if (tmr != 16'hFFFF)
                        tmr++;
                    if (tmr >= lim)
                        enter(RX_HUNT);
                end
            end
            OP_READ: begin
                r.result_kind = 1'b1;
                r.read_data = (it.read_address < STORE_SZ) ? pix_mem[it.read_address] : 8'h00;
                result_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sync_sr  = '0;
            field_sr = '0;
            crc_acc  = '1;
            body_len = 0;
            hdr_lim  = HDR_TIMEOUT_RST;
            pay_lim  = PAY_TIMEOUT_RST;
            enter(RX_HUNT);
            for (int i = 0; i < STORE_SZ; i++)
                pix_mem[i] = 8'hFF;
            result_q.delete();
            fail_count = 0;
        end
        else begin
            // results leave before new items enter: latency is never zero
            if (out_ch.valid && out_ch.ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, out_ch.payload);
                    fail_count++;
                end
                else begin
                    exp_res = result_q.pop_front();
                    if (exp_res !== out_ch.payload) begin
                        $display("%0t: result mismatch, expected %h actual %h",
                                 $time, exp_res, out_ch.payload);
                        fail_count++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_HDR_TIMEOUT)
                    hdr_lim = cfg_data;
                else
                    pay_lim = cfg_data;
            end
            if (in_ch.valid && in_ch.ready)
                take_item(in_ch.payload);
        end
        pending = result_q.size();
    end

endmodule

/* tb/sv/framed_rect_update_receiver_tb.sv */
module framed_rect_update_receiver_tb;
    import frud_pkg::*;

    localparam int unsigned PANEL_W  = DEF_PANEL_WIDTH;
    localparam int unsigned PANEL_H  = DEF_PANEL_HEIGHT;
    localparam int unsigned STORE_SZ = ((PANEL_W + 7) / 8) * PANEL_H;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;

    // stimulus knobs, percent of cycles
    int send_idle_pct;
    int sink_stall_pct;
    // long receiver hold-off handshake between stimulus and ready driver
    int hold_req;
    int hold_done;
    int hold_left;
    int sent_items;

    logic [7:0] body_q [$];

    frud_in_if  in_ch ();
    frud_out_if out_ch ();

    framed_rect_update_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frud_tb_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Result side ready: random stalls, plus a long hold-off on request so the
    // block backs up and stops taking input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
            hold_done = 0;
        end
        else if (hold_req != hold_done)
        begin
            hold_done = hold_req;
            hold_left = 3000;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8)
            r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        return r;
    endfunction

    // One transfer on the input channel. Valid stays high into the next call
    // unless a gap is drawn, so back-to-back items never toggle valid.
    task automatic push_item(input op_t op, input logic [7:0] b, input logic [14:0] a);
        in_item_t it;
        it.operation    = op;
        it.rx_byte      = b;
        it.read_address = a;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (op != OP_NONE)
            sent_items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_item(OP_BYTE, b, 15'($urandom));
    endtask

    task automatic send_tick();
        push_item(OP_TICK, 8'($urandom), 15'($urandom));
    endtask

    task automatic send_read(input logic [14:0] a);
        push_item(OP_READ, 8'($urandom), a);
    endtask

    task automatic send_rand_read();
        if ($urandom_range(9) == 0)
            send_read(15'($urandom));
        else
            send_read(15'($urandom_range(STORE_SZ - 1)));
    endtask

    // Sync word, length, body_q, CRC. Ticks and reads can be sprinkled into
    // the body; a bad CRC flips one bit.
    task automatic send_frame(input logic [31:0] len, input bit crc_bad, input int mix_pct);
        logic [31:0] c;
        c = '1;
        foreach (body_q[i])
            c = crc_next(c, body_q[i]);
        c = ~c;
        if (crc_bad)
            c ^= 32'h1 << $urandom_range(31);
        for (int i = 3; i >= 0; i--)
            send_byte(SYNC_WORD[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            send_byte(len[8*i +: 8]);
        foreach (body_q[i])
        begin
            if (mix_pct > 0 && $urandom_range(99) < mix_pct)
            begin
                if ($urandom_range(1) == 0)
                    send_tick();
                else
                    send_rand_read();
            end
            send_byte(body_q[i]);
        end
        for (int i = 0; i < 4; i++)
            send_byte(c[8*i +: 8]);
    endtask

    // Rectangle body sized for the clipped area (raw size when off panel).
    task automatic build_rect(input logic [7:0] flags, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] w,
                              input logic [15:0] h);
        int unsigned cw, ch, n;
        cw = w;
        ch = h;
        if (x < PANEL_W && x + w > PANEL_W)
            cw = PANEL_W - x;
        if (y < PANEL_H && y + h > PANEL_H)
            ch = PANEL_H - y;
        n = (cw / 8) * ch;
        if (n > STORE_SZ)
            n = 16;
        body_q.delete();
        body_q.push_back(flags);
        body_q.push_back(x[7:0]);
        body_q.push_back(x[15:8]);
        body_q.push_back(y[7:0]);
        body_q.push_back(y[15:8]);
        body_q.push_back(w[7:0]);
        body_q.push_back(w[15:8]);
        body_q.push_back(h[7:0]);
        body_q.push_back(h[15:8]);
        repeat (n)
            body_q.push_back(8'($urandom));
    endtask

    task automatic send_rect(input logic [7:0] flags, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] w,
                             input logic [15:0] h);
        build_rect(flags, x, y, w, h);
        send_frame(body_q.size(), 1'b0, 0);
    endtask

    // Mostly small windows; a fifth sit near the right/bottom edges to clip.
    task automatic rand_rect_body();
        logic [15:0] x, y, w, h;
        logic [7:0]  flags;
        w = 16'(8 * $urandom_range(1, 5));
        h = 16'($urandom_range(1, 4));
        if ($urandom_range(4) == 0)
        begin
            x = 16'(8 * $urandom_range(95, 98));
            y = 16'($urandom_range(267, 271));
        end
        else
        begin
            x = 16'(8 * $urandom_range(0, 98));
            y = 16'($urandom_range(0, 271));
        end
        // random flag bits with the rect bit forced; random full-redraw bit kept one time in four
        flags = 8'($urandom) | 8'h02;
        if ($urandom_range(3) != 0)
            flags[BIT_FULL] = 1'b0;
        build_rect(flags, x, y, w, h);
    endtask

    task automatic run_random(input int n);
        int stop, k;
        stop = sent_items + n;
        while (sent_items < stop)
        begin
            k = $urandom_range(99);
            if (k < 55)
            begin
                rand_rect_body();
                send_frame(body_q.size(), 1'b0, 3);
            end
            else if (k < 65)
            begin
                // broken frames: bad CRC, wrong length, misaligned x, wrong full size
                rand_rect_body();
                case ($urandom_range(3))
                    0: send_frame(body_q.size(), 1'b1, 0);
                    1: send_frame(body_q.size() + 1, 1'b0, 0);
                    2:
                    begin
                        body_q[1] = body_q[1] | 8'($urandom_range(1, 7));
                        send_frame(body_q.size(), 1'b0, 0);
                    end
                    default:
                    begin
                        body_q[0] = body_q[0] & 8'hFD;
                        send_frame(body_q.size(), 1'b0, 0);
                    end
                endcase
            end
            else if (k < 85)
                repeat ($urandom_range(1, 4))
                    send_rand_read();
            else if (k < 93)
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(3) == 0) ? 8'h4D : 8'($urandom));
            else if (k < 98)
                repeat ($urandom_range(1, 3))
                    send_tick();
            else
                push_item(OP_NONE, 8'($urandom), 15'($urandom));
        end
    endtask

    // Idle point: drop valid, let all results drain, then let trailing
    // byte/tick work settle before touching registers.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        #(12 * 500000);
        $display("[framed_rect_update_receiver] ERROR");
        $finish;
    end

    initial
    begin
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_HDR_TIMEOUT;
        cfg_data       = '0;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        hold_req       = 0;
        sent_items     = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed, reset timeouts, no idling ----
        send_read(15'd0);                   // white after reset
        send_read(15'(STORE_SZ - 1));
        send_read(15'(STORE_SZ));           // beyond the store
        send_read(15'h7FFF);
        push_item(OP_NONE, 8'hFF, 15'h7FFF);
        send_tick();                        // tick while hunting
        send_byte(8'h4D);                   // stray prefix before sync
        send_rect(8'h02, 16'd0, 16'd0, 16'd8, 16'd1);
        send_rect(8'h02, 16'd784, 16'd271, 16'd16, 16'd2);   // clipped both ways
        send_rect(8'h03, 16'd8, 16'd4, 16'd8, 16'd2);        // rect with full redraw
        send_rect(8'h02, 16'd3, 16'd0, 16'd8, 16'd1);        // x misaligned
        send_rect(8'h02, 16'd0, 16'd0, 16'd9, 16'd1);        // w misaligned
        send_rect(8'h02, 16'd0, 16'd0, 16'd0, 16'd1);        // w zero
        send_rect(8'h02, 16'd0, 16'd0, 16'd8, 16'd0);        // h zero
        send_rect(8'h02, 16'd792, 16'd0, 16'd8, 16'd1);      // x off panel
        send_rect(8'h02, 16'd0, 16'd272, 16'd8, 16'd1);      // y off panel
        build_rect(8'h02, 16'd16, 16'd16, 16'd8, 16'd2);
        send_frame(body_q.size(), 1'b1, 0);                   // bad CRC
        body_q = '{8'h02, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(5, 1'b0, 0);                               // rect too short
        body_q = '{8'h00, 8'hAA};
        send_frame(2, 1'b0, 0);                               // wrong full size
        body_q.delete();
        send_frame(0, 1'b0, 0);                               // length zero
        send_frame(32'(STORE_SZ + 10), 1'b0, 0);              // length too big
        send_read(15'd0);
        send_read(15'd8);
        send_read(15'(4 * 99 + 1));
        repeat (20)
            send_rand_read();

        // ---- random, reset timeouts, no idling ----
        run_random(200);

        // ---- shortest timeouts, sender mostly idle ----
        drain();
        write_reg(REG_HDR_TIMEOUT, 16'd1);
        write_reg(REG_PAY_TIMEOUT, 16'd1);
        send_idle_pct = 78;
        run_random(200);

        // ---- longest timeouts, receiver mostly stalled, with a long hold-off ----
        drain();
        write_reg(REG_HDR_TIMEOUT, 16'hFFFF);
        write_reg(REG_PAY_TIMEOUT, 16'hFFFF);
        send_idle_pct  = 0;
        sink_stall_pct = 78;
        hold_req++;
        repeat (40)
            send_rand_read();
        run_random(200);

        // ---- small random timeouts, both sides idling a little ----
        drain();
        write_reg(REG_HDR_TIMEOUT, 16'($urandom_range(2, 20)));
        write_reg(REG_PAY_TIMEOUT, 16'($urandom_range(2, 40)));
        send_idle_pct  = 11;
        sink_stall_pct = 11;
        run_random(200);

        drain();
        repeat (200)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[framed_rect_update_receiver] OK");
        else
            $display("[framed_rect_update_receiver] ERROR");
        $finish;
    end

endmodule

/* framed_rect_update_receiver.f */
sv/frud_pkg.sv
sv/frud_if.sv
sv/frud_ctrl.sv
sv/frud_dp.sv
sv/framed_rect_update_receiver.sv
sv/frud_checker.sv
tb/sv/frud_checker.sv
tb/sv/framed_rect_update_receiver_tb.sv
